// ----- sv/asc_pkg.sv -----
`timescale 1ns / 1ps
// Package for the adaptive step size controller: number format, register
// indexes, controller modes and coefficients. No dependencies.
package asc_pkg;

	localparam int FRAC_BITS = 32;
	localparam int INT_BITS  = 16;
	localparam int VAL_BITS  = FRAC_BITS + INT_BITS;
	localparam int DVD_W     = VAL_BITS + FRAC_BITS;
	localparam int IDX_W     = 3;
	localparam int TAYLOR_TERMS = 24;

	localparam logic [VAL_BITS-1:0] VMAX   = '1;
	localparam logic [VAL_BITS-1:0] ONE_FX = VAL_BITS'(64'd1 << FRAC_BITS);
	localparam logic [63:0] FLOOR_RAW = ((64'd1 << FRAC_BITS) + 64'd50000000) / 64'd100000000;
	localparam logic [VAL_BITS-1:0] ERR_FLOOR =
		(FLOOR_RAW > 64'd0) ? VAL_BITS'(FLOOR_RAW) : VAL_BITS'(1);
	localparam logic [63:0] Q62_ONE = 64'd1 << 62;
	localparam logic [63:0] LN2_Q62 = 64'h2C5C85FDF473DE6B;

	localparam logic [IDX_W-1:0] REG_ACC_EN  = 3'd0;
	localparam logic [IDX_W-1:0] REG_TOL     = 3'd1;
	localparam logic [IDX_W-1:0] REG_VOLUME  = 3'd2;
	localparam logic [IDX_W-1:0] REG_MODE    = 3'd3;
	localparam logic [IDX_W-1:0] REG_SECOND  = 3'd4;
	localparam logic [IDX_W-1:0] REG_MIN     = 3'd5;
	localparam logic [IDX_W-1:0] REG_MAX     = 3'd6;

	localparam logic [1:0] MODE_I   = 2'd0;
	localparam logic [1:0] MODE_PI  = 2'd1;
	localparam logic [1:0] MODE_PID = 2'd2;
	localparam logic [1:0] MODE_INV = 2'd3;

	// weight in hundredths; sel 0 new ratio, 1 latest, 2 previous
	function automatic logic signed [7:0] coef(input logic [1:0] mode, input logic [1:0] sel);
		logic signed [7:0] c;
		c = 8'sd0;
		case (mode)
			MODE_I: begin
				if (sel == 2'd0) c = -8'sd100;
			end
			MODE_PI: begin
				if (sel == 2'd0) c = -8'sd70;
				else if (sel == 2'd1) c = 8'sd40;
			end
			MODE_PID: begin
				if (sel == 2'd0) c = -8'sd49;
				else if (sel == 2'd1) c = 8'sd34;
				else if (sel == 2'd2) c = -8'sd10;
			end
			default: c = 8'sd0;
		endcase
		return c;
	endfunction

endpackage

// ----- sv/asc_ifs.sv -----
`timescale 1ns / 1ps
// Valid/ready channel interfaces of the step size controller: input item,
// result item and configuration write. Depends on asc_pkg.
interface asc_in_if;
	logic                          valid;
	logic                          ready;
	logic [asc_pkg::VAL_BITS-1:0]  error_estimate;
	logic [asc_pkg::VAL_BITS-1:0]  step_size;
	logic [asc_pkg::VAL_BITS-1:0]  last_estimate;
	modport source (output valid, error_estimate, step_size, last_estimate, input ready);
	modport sink (input valid, error_estimate, step_size, last_estimate, output ready);
endinterface

interface asc_out_if;
	logic                          valid;
	logic                          ready;
	logic [asc_pkg::VAL_BITS-1:0]  new_step;
	modport source (output valid, new_step, input ready);
	modport sink (input valid, new_step, output ready);
endinterface

interface asc_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [asc_pkg::IDX_W-1:0]     index;
	logic [asc_pkg::VAL_BITS-1:0]  data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ----- sv/adaptive_step_size_controller_core.sv -----
`timescale 1ns / 1ps
// Step size controller core: I/PI/PID/inverse step control in Q16.32 on one
// shared 32x32 multiplier, one restoring divider and a one-bit shifter.
// Depends on asc_pkg and the channel interfaces in asc_ifs.sv.
//
// channel  role    payload
// cfg      sink    index, data (register write, always ready)
// sample   sink    error_estimate, step_size, last_estimate
// result   source  new_step
//
// An item takes longer in I/PI/PID modes than in inverse mode; the Taylor
// series (24 multiply and divide rounds on the shared units) sets most of
// it. Reset loads the register defaults and an error history of one. A
// result held by a stalled sink blocks only the next finish; sample is
// ready whenever the sequencer is idle.
module adaptive_step_size_controller_core (
	input logic clk,
	input logic arst_n,
	asc_cfg_if.sink cfg,
	asc_in_if.sink sample,
	asc_out_if.source result
);

	localparam int VB = asc_pkg::VAL_BITS;
	localparam int FB = asc_pkg::FRAC_BITS;
	localparam int DW = asc_pkg::DVD_W;

	typedef enum logic [4:0] {
		S_IDLE, S_MUL, S_DIV, S_D1R, S_D2R, S_D3R, S_LNI, S_LNN, S_LSQ, S_LAC,
		S_YQ, S_TI, S_TD, S_TA, S_SH0, S_SH, S_CAPL, S_CAPR, S_FIN, S_DONE
	} state_t;

	state_t state_q, ret_q;
	logic [6:0] cnt_q;
	logic [4:0] loop_q;
	logic [1:0] sel_q;

	logic acc_en_q, second_q;
	logic [1:0] mode_q;
	logic [VB-1:0] tol_q, vol_q, min_q, max_q;
	logic [VB-1:0] err_prev_q, err_lat_q, cur_q, old_q, r_q;
	logic [VB-1:0] dt_q, last_q, step_q, out_q;
	logic out_valid_q;

	logic [63:0] ma_q, mb_q, sum_q, t_q;
	logic [127:0] acc_q;
	logic [DW-1:0] dvd_q;
	logic [VB-1:0] dvs_q, rem_q;
	logic [5:0] p_q;
	logic [FB-1:0] frac_q;
	logic signed [49:0] y_q;
	logic signed [17:0] n_q;

	// shared multiplier, one 32x32 partial product per cycle
	logic [31:0] a_h, b_h;
	logic [63:0] pp;
	logic [127:0] pp_sh;
	always_comb begin
		a_h = cnt_q[0] ? ma_q[63:32] : ma_q[31:0];
		b_h = cnt_q[1] ? mb_q[63:32] : mb_q[31:0];
		pp = 64'(a_h) * 64'(b_h);
		case (cnt_q[1:0])
			2'd0: pp_sh = {64'd0, pp};
			2'd3: pp_sh = {pp, 64'd0};
			default: pp_sh = {32'd0, pp, 32'd0};
		endcase
	end
	logic [63:0] m62;
	assign m62 = acc_q[125:62];

	// shared restoring divider, one quotient bit per cycle
	logic [VB:0] rem_n;
	logic ge;
	logic [VB-1:0] rem_d;
	always_comb begin
		rem_n = {rem_q, dvd_q[DW-1]};
		ge = rem_n >= {1'b0, dvs_q};
		rem_d = ge ? VB'(rem_n - {1'b0, dvs_q}) : rem_n[VB-1:0];
	end
	logic [VB-1:0] q_sat;
	assign q_sat = (dvd_q[DW-1:VB] != '0) ? asc_pkg::VMAX : dvd_q[VB-1:0];
	logic [VB-1:0] r_fl;
	assign r_fl = (q_sat < asc_pkg::ERR_FLOOR) ? asc_pkg::ERR_FLOOR : q_sat;

	// log2 accumulation
	logic [VB-1:0] log_x;
	logic [5:0] pm;
	logic signed [37:0] l_val;
	logic signed [7:0] c_s;
	logic signed [45:0] cl;
	logic signed [49:0] y_next;
	always_comb begin
		case (sel_q)
			2'd0: log_x = r_q;
			2'd1: log_x = cur_q;
			default: log_x = old_q;
		endcase
		pm = p_q - 6'(FB);
		l_val = $signed({pm, frac_q});
		c_s = asc_pkg::coef(mode_q, sel_q);
		cl = $signed({{38{c_s[7]}}, c_s}) * $signed({{8{l_val[37]}}, l_val});
		y_next = y_q + {{4{cl[45]}}, cl};
	end

	logic [63:0] m_sq, m_adj;
	assign m_sq = m62;
	assign m_adj = m_sq[63] ? {1'b0, m_sq[63:1]} : m_sq;

	logic signed [49:0] yq;
	assign yq = y_q[49] ? -$signed(dvd_q[49:0]) : $signed(dvd_q[49:0]);

	logic signed [18:0] sv;
	assign sv = 19'sd62 - {n_q[17], n_q};

	logic [63:0] sum_n;
	assign sum_n = sum_q + dvd_q[63:0];

	logic [VB:0] cap_sum;
	logic [VB-1:0] cap_v, clamp_lo, clamp_hi;
	always_comb begin
		cap_sum = {1'b0, last_q} + {1'b0, dvd_q[VB-1:0]};
		cap_v = cap_sum[VB] ? asc_pkg::VMAX : cap_sum[VB-1:0];
		clamp_lo = (step_q < min_q) ? min_q : step_q;
		clamp_hi = (clamp_lo > max_q) ? max_q : clamp_lo;
	end

	assign cfg.ready = 1'b1;
	assign sample.ready = (state_q == S_IDLE);
	assign result.valid = out_valid_q;
	assign result.new_step = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ret_q <= S_IDLE;
			cnt_q <= '0;
			loop_q <= '0;
			sel_q <= '0;
			acc_en_q <= 1'b0;
			tol_q <= asc_pkg::ONE_FX;
			vol_q <= asc_pkg::ONE_FX;
			mode_q <= asc_pkg::MODE_INV;
			second_q <= 1'b0;
			min_q <= '0;
			max_q <= asc_pkg::VMAX;
			err_prev_q <= asc_pkg::ONE_FX;
			err_lat_q <= asc_pkg::ONE_FX;
			cur_q <= '0;
			old_q <= '0;
			r_q <= '0;
			dt_q <= '0;
			last_q <= '0;
			step_q <= '0;
			out_q <= '0;
			out_valid_q <= 1'b0;
			ma_q <= '0;
			mb_q <= '0;
			sum_q <= '0;
			t_q <= '0;
			acc_q <= '0;
			dvd_q <= '0;
			dvs_q <= '0;
			rem_q <= '0;
			p_q <= '0;
			frac_q <= '0;
			y_q <= '0;
			n_q <= '0;
		end else begin
			if (cfg.valid) begin
				case (cfg.index)
					asc_pkg::REG_ACC_EN: acc_en_q <= cfg.data[0];
					asc_pkg::REG_TOL:    tol_q <= cfg.data;
					asc_pkg::REG_VOLUME: vol_q <= cfg.data;
					asc_pkg::REG_MODE:   mode_q <= cfg.data[1:0];
					asc_pkg::REG_SECOND: second_q <= cfg.data[0];
					asc_pkg::REG_MIN:    min_q <= cfg.data;
					asc_pkg::REG_MAX:    max_q <= cfg.data;
					default: ;
				endcase
			end
			if (result.ready && state_q != S_DONE) out_valid_q <= 1'b0;

			case (state_q)
				S_IDLE: begin
					if (sample.valid) begin
						dt_q <= sample.step_size;
						last_q <= sample.last_estimate;
						if (acc_en_q) begin
							dvd_q <= {sample.error_estimate, FB'(0)};
							dvs_q <= tol_q;
							rem_q <= '0;
							cnt_q <= '0;
							ret_q <= S_D1R;
							state_q <= S_DIV;
						end else begin
							step_q <= asc_pkg::VMAX;
							state_q <= S_FIN;
						end
					end
				end
				S_MUL: begin
					acc_q <= acc_q + pp_sh;
					cnt_q <= cnt_q + 7'd1;
					if (cnt_q[1:0] == 2'd3) state_q <= ret_q;
				end
				S_DIV: begin
					rem_q <= rem_d;
					dvd_q <= {dvd_q[DW-2:0], ge};
					cnt_q <= cnt_q + 7'd1;
					if (cnt_q == 7'(DW - 1)) state_q <= ret_q;
				end
				S_D1R: begin
					dvd_q <= {q_sat, FB'(0)};
					dvs_q <= vol_q;
					rem_q <= '0;
					cnt_q <= '0;
					ret_q <= S_D2R;
					state_q <= S_DIV;
				end
				S_D2R: begin
					r_q <= r_fl;
					cur_q <= err_lat_q;
					old_q <= err_prev_q;
					err_prev_q <= err_lat_q;
					err_lat_q <= r_fl;
					if (mode_q == asc_pkg::MODE_INV) begin
						dvd_q <= {dt_q, FB'(0)};
						dvs_q <= r_fl;
						rem_q <= '0;
						cnt_q <= '0;
						ret_q <= S_D3R;
						state_q <= S_DIV;
					end else begin
						sel_q <= '0;
						y_q <= '0;
						state_q <= S_LNI;
					end
				end
				S_D3R: begin
					step_q <= q_sat;
					state_q <= S_CAPL;
				end
				S_LNI: begin
					ma_q <= {16'd0, (log_x == '0) ? VB'(1) : log_x};
					p_q <= 6'd62;
					state_q <= S_LNN;
				end
				S_LNN: begin
					if (ma_q[62]) begin
						mb_q <= ma_q;
						loop_q <= '0;
						frac_q <= '0;
						acc_q <= '0;
						cnt_q <= '0;
						ret_q <= S_LSQ;
						state_q <= S_MUL;
					end else begin
						ma_q <= {ma_q[62:0], 1'b0};
						p_q <= p_q - 6'd1;
					end
				end
				S_LSQ: begin
					frac_q <= {frac_q[FB-2:0], m_sq[63]};
					if (loop_q == 5'(FB - 1)) begin
						state_q <= S_LAC;
					end else begin
						loop_q <= loop_q + 5'd1;
						ma_q <= m_adj;
						mb_q <= m_adj;
						acc_q <= '0;
						cnt_q <= '0;
						ret_q <= S_LSQ;
						state_q <= S_MUL;
					end
				end
				S_LAC: begin
					y_q <= y_next;
					if (sel_q == 2'd2) begin
						dvd_q <= DW'(y_next[49] ? 50'(-y_next) : 50'(y_next));
						dvs_q <= second_q ? VB'(200) : VB'(100);
						rem_q <= '0;
						cnt_q <= '0;
						ret_q <= S_YQ;
						state_q <= S_DIV;
					end else begin
						sel_q <= sel_q + 2'd1;
						state_q <= S_LNI;
					end
				end
				S_YQ: begin
					n_q <= yq[49:32];
					ma_q <= {2'b00, yq[31:0], 30'd0};
					mb_q <= asc_pkg::LN2_Q62;
					acc_q <= '0;
					cnt_q <= '0;
					ret_q <= S_TI;
					state_q <= S_MUL;
				end
				S_TI: begin
					t_q <= m62;
					sum_q <= asc_pkg::Q62_ONE;
					loop_q <= 5'd1;
					ma_q <= asc_pkg::Q62_ONE;
					mb_q <= m62;
					acc_q <= '0;
					cnt_q <= '0;
					ret_q <= S_TD;
					state_q <= S_MUL;
				end
				S_TD: begin
					dvd_q <= DW'(m62);
					dvs_q <= VB'(loop_q);
					rem_q <= '0;
					cnt_q <= '0;
					ret_q <= S_TA;
					state_q <= S_DIV;
				end
				S_TA: begin
					sum_q <= sum_n;
					acc_q <= '0;
					cnt_q <= '0;
					state_q <= S_MUL;
					if (loop_q == 5'(asc_pkg::TAYLOR_TERMS)) begin
						ma_q <= {16'd0, dt_q};
						mb_q <= sum_n;
						ret_q <= S_SH0;
					end else begin
						loop_q <= loop_q + 5'd1;
						ma_q <= dvd_q[63:0];
						mb_q <= t_q;
						ret_q <= S_TD;
					end
				end
				S_SH0: begin
					if (sv < 19'sd0) begin
						step_q <= (acc_q[111:0] != '0) ? asc_pkg::VMAX : '0;
						state_q <= S_CAPL;
					end else if (sv >= 19'sd112) begin
						step_q <= '0;
						state_q <= S_CAPL;
					end else begin
						cnt_q <= sv[6:0];
						state_q <= S_SH;
					end
				end
				S_SH: begin
					if (cnt_q == '0) begin
						step_q <= (acc_q[127:VB] != '0) ? asc_pkg::VMAX : acc_q[VB-1:0];
						state_q <= S_CAPL;
					end else begin
						acc_q <= {1'b0, acc_q[127:1]};
						cnt_q <= cnt_q - 7'd1;
					end
				end
				S_CAPL: begin
					dvd_q <= DW'(last_q);
					dvs_q <= VB'(10);
					rem_q <= '0;
					cnt_q <= '0;
					ret_q <= S_CAPR;
					state_q <= S_DIV;
				end
				S_CAPR: begin
					if (cap_v < step_q) step_q <= cap_v;
					state_q <= S_FIN;
				end
				S_FIN: begin
					step_q <= clamp_hi;
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (!out_valid_q || result.ready) begin
						out_q <= step_q;
						out_valid_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
